### src/ps2mc_pkg.sv
// ps2mc_pkg: shared types and constants for the ps/2 mouse packet cursor block
// used by the framer, cursor and top level modules, no dependencies
package ps2mc_pkg;

    localparam int COORD_W = 11;
    localparam int BYTE_W  = 8;
    localparam int BTN_W   = 3;
    localparam int DX_W    = 9;
    localparam int DY_W    = 10;
    localparam int OUT_W   = 48;

    localparam logic [BYTE_W-1:0] ACK_BYTE   = 8'hFA;
    localparam logic [BYTE_W-1:0] SYNC_MASK  = 8'hC8;
    localparam logic [BYTE_W-1:0] SYNC_VALUE = 8'h08;

    localparam int SIGN_X_BIT = 4;
    localparam int SIGN_Y_BIT = 5;

    localparam logic [COORD_W-1:0] RESET_LIMIT_X = 11'd1024;
    localparam logic [COORD_W-1:0] RESET_LIMIT_Y = 11'd768;

    // configuration register indexes
    localparam logic CFG_LIMIT_X = 1'b0;
    localparam logic CFG_LIMIT_Y = 1'b1;

    typedef enum logic [3:0] {
        PH_ACK = 4'b0001,
        PH_HDR = 4'b0010,
        PH_X   = 4'b0100,
        PH_Y   = 4'b1000
    } t_phase;

    // one framed packet, valid for one cycle when the y byte is accepted
    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] x_byte;
        logic [BYTE_W-1:0] y_byte;
    } t_pkt;

endpackage

### src/ps2mc_framer.sv
// ps2mc_framer: waits for the acknowledge byte, then frames 3-byte packets
// depends on ps2mc_pkg
module ps2mc_framer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [ps2mc_pkg::BYTE_W-1:0]  i_byte,
    output ps2mc_pkg::t_pkt               o_pkt
);

    ps2mc_pkg::t_phase             r_phase, n_phase;
    logic [ps2mc_pkg::BYTE_W-1:0]  r_header, n_header;
    logic [ps2mc_pkg::BYTE_W-1:0]  r_x_byte, n_x_byte;
    logic                          w_done;

    always_comb begin
        n_phase  = r_phase;
        n_header = r_header;
        n_x_byte = r_x_byte;
        w_done   = 1'b0;
        if (i_accept) begin
            unique case (r_phase)
                ps2mc_pkg::PH_ACK: begin
                    if (i_byte == ps2mc_pkg::ACK_BYTE) n_phase = ps2mc_pkg::PH_HDR;
                end
                ps2mc_pkg::PH_HDR: begin
                    // header only when bit 3 set and bits 6, 7 clear
                    if ((i_byte & ps2mc_pkg::SYNC_MASK) == ps2mc_pkg::SYNC_VALUE) begin
                        n_header = i_byte;
                        n_phase  = ps2mc_pkg::PH_X;
                    end
                end
                ps2mc_pkg::PH_X: begin
                    n_x_byte = i_byte;
                    n_phase  = ps2mc_pkg::PH_Y;
                end
                ps2mc_pkg::PH_Y: begin
                    w_done  = 1'b1;
                    n_phase = ps2mc_pkg::PH_HDR;
                end
                default: begin
                    n_phase = ps2mc_pkg::PH_ACK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ps2mc_pkg::PH_ACK;
            r_header <= '0;
            r_x_byte <= '0;
        end else begin
            r_phase  <= n_phase;
            r_header <= n_header;
            r_x_byte <= n_x_byte;
        end
    end

    assign o_pkt.done   = w_done;
    assign o_pkt.header = r_header;
    assign o_pkt.x_byte = r_x_byte;
    assign o_pkt.y_byte = i_byte;

endmodule

### src/ps2mc_cursor.sv
// ps2mc_cursor: delta decode, clamped cursor position and the result register
// depends on ps2mc_pkg
module ps2mc_cursor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [ps2mc_pkg::COORD_W-1:0]   i_cfg_data,
    input  ps2mc_pkg::t_pkt                 i_pkt,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [ps2mc_pkg::BTN_W-1:0]     o_buttons,
    output logic signed [ps2mc_pkg::DX_W-1:0] o_delta_x,
    output logic signed [ps2mc_pkg::DY_W-1:0] o_delta_y,
    output logic [ps2mc_pkg::COORD_W-1:0]   o_cursor_x,
    output logic [ps2mc_pkg::COORD_W-1:0]   o_cursor_y
);

    localparam int SUM_W = ps2mc_pkg::COORD_W + 2;

    logic [ps2mc_pkg::COORD_W-1:0]   r_limit_x, r_limit_y;
    logic [ps2mc_pkg::COORD_W-1:0]   r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic                            r_valid, n_valid;
    logic [ps2mc_pkg::BTN_W-1:0]     r_buttons;
    logic signed [ps2mc_pkg::DX_W-1:0] r_dx, w_dx;
    logic signed [ps2mc_pkg::DY_W-1:0] r_dy, w_dy;
    logic signed [ps2mc_pkg::DX_W-1:0] w_dy_raw;

    function automatic logic [ps2mc_pkg::COORD_W-1:0] clamp_axis(
        input logic [ps2mc_pkg::COORD_W-1:0] pos,
        input logic signed [ps2mc_pkg::DY_W-1:0] delta,
        input logic [ps2mc_pkg::COORD_W-1:0] limit
    );
        logic signed [SUM_W-1:0] sum;
        logic [ps2mc_pkg::COORD_W-1:0] res;
        sum = $signed({2'b00, pos}) + SUM_W'(delta);
        if (sum < 0) res = '0;
        else if (sum > $signed({2'b00, limit})) res = limit;
        else res = sum[ps2mc_pkg::COORD_W-1:0];
        return res;
    endfunction

    // header sign bits alone give each delta's sign
    assign w_dx     = $signed({i_pkt.header[ps2mc_pkg::SIGN_X_BIT], i_pkt.x_byte});
    assign w_dy_raw = $signed({i_pkt.header[ps2mc_pkg::SIGN_Y_BIT], i_pkt.y_byte});
    // negate so that down is positive
    assign w_dy     = -(ps2mc_pkg::DY_W'(w_dy_raw));

    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        if (i_pkt.done) begin
            n_pos_x = clamp_axis(r_pos_x, ps2mc_pkg::DY_W'(w_dx), r_limit_x);
            n_pos_y = clamp_axis(r_pos_y, w_dy, r_limit_y);
        end
        n_valid = i_pkt.done | (r_valid & ~i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_x <= ps2mc_pkg::RESET_LIMIT_X;
            r_limit_y <= ps2mc_pkg::RESET_LIMIT_Y;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ps2mc_pkg::CFG_LIMIT_X: r_limit_x <= i_cfg_data;
                    ps2mc_pkg::CFG_LIMIT_Y: r_limit_y <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_valid <= n_valid;
        end
    end

    // payload loads only when a packet completes
    always_ff @(posedge i_clk) begin
        if (i_pkt.done) begin
            r_buttons <= i_pkt.header[ps2mc_pkg::BTN_W-1:0];
            r_dx      <= w_dx;
            r_dy      <= w_dy;
        end
    end

    assign o_out_valid = r_valid;
    assign o_buttons   = r_buttons;
    assign o_delta_x   = r_dx;
    assign o_delta_y   = r_dy;
    assign o_cursor_x  = r_pos_x;
    assign o_cursor_y  = r_pos_y;

endmodule

### src/ps2_mouse_packet_cursor_unit.sv
// ps2_mouse_packet_cursor_unit: top level of the ps/2 mouse packet cursor block
// depends on ps2mc_pkg, ps2mc_framer and ps2mc_cursor
//
// usage:
//   slave stream (i_s_*) takes one mouse byte per request in tdata[7:0].
//   after reset, bytes are dropped until the acknowledge byte 0xfa arrives;
//   then bytes are framed as header, x byte, y byte. a header that fails the
//   sync test is dropped and the framer keeps waiting for a header.
//   master stream (o_m_*) gives one result per completed packet, 48-bit tdata.
//   config port: i_cfg_we writes i_cfg_data into limit_x (index 0) or
//   limit_y (index 1); write only while no request is pending (not enforced by the block).
//   the result is registered, valid in the cycle after the y byte is accepted.
//   throughput: one byte per cycle unless stalled, set by the single result register;
//   a new y byte may be taken in the cycle the previous result is taken.
//   stall: when the result waits and i_m_tready is low, o_s_tready drops;
//   it returns as soon as the result is taken.
//   reset: synchronous, active low; limits go to 1024 and 768, cursor to 0,
//   framer back to waiting for the acknowledge byte, no result pending.
module ps2_mouse_packet_cursor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data,
    // byte stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // result stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // [2:0] buttons, [11:3] delta_x, [21:12] delta_y,
                                     // [32:22] cursor_x, [43:33] cursor_y, rest zero
);

    ps2mc_pkg::t_pkt                       w_pkt;
    logic                                  w_accept;
    logic [ps2mc_pkg::BTN_W-1:0]           w_buttons;
    logic signed [ps2mc_pkg::DX_W-1:0]     w_dx;
    logic signed [ps2mc_pkg::DY_W-1:0]     w_dy;
    logic [ps2mc_pkg::COORD_W-1:0]         w_cx, w_cy;

    assign o_s_tready = ~o_m_tvalid | i_m_tready;
    assign w_accept   = i_s_tvalid & o_s_tready;

    ps2mc_framer u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_tdata),
        .o_pkt    (w_pkt)
    );

    ps2mc_cursor u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pkt       (w_pkt),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_buttons   (w_buttons),
        .o_delta_x   (w_dx),
        .o_delta_y   (w_dy),
        .o_cursor_x  (w_cx),
        .o_cursor_y  (w_cy)
    );

    assign o_m_tdata = {4'b0000, w_cy, w_cx, w_dy, w_dx, w_buttons};

endmodule

### src/ps2mc_checker.sv
// ps2mc_checker: port-level assertions for ps2_mouse_packet_cursor_unit
// bound to the top level below; depends on nothing else
module ps2mc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_cfg_index,
    input logic [10:0] i_cfg_data,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata
);

    // a stalled result stays
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // a new result only follows an accepted byte
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready))
        else $error("result without an accepted byte");

    // input backpressure only when the result register is full and stalled
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output slot");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result pending after reset");

endmodule

bind ps2_mouse_packet_cursor_unit ps2mc_checker u_ps2mc_checker (.*);
